// ===== rtl/sdcr_pkg.sv =====
`timescale 1ns / 1ps

package sdcr_pkg;

	localparam int PULSE_WIDTH = 12;
	localparam int SUM_WIDTH = PULSE_WIDTH + 2;
	localparam int ROW_WIDTH = 4 * PULSE_WIDTH;
	localparam int OFFSET_WIDTH = 10;
	localparam int DURATION_WIDTH = 15;
	localparam int COUNT_WIDTH = 16;
	localparam int OFFSET_ROM_DEPTH = 51;
	localparam int ROM_LAST = OFFSET_ROM_DEPTH - 1;
	localparam int ROM_INDEX_WIDTH = $clog2(OFFSET_ROM_DEPTH);
	localparam int REVERSE_PAUSE_TICKS = 40;

	localparam int NEUTRAL_WIDTH = 307;
	localparam int MIN_WIDTH = 143;
	localparam int MAX_WIDTH = 471;
	localparam int SPEED_FULL = 4;

	typedef enum logic [1:0] {
		CMD_DRIVE = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_HALT  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_TIMED = 2'd1,
		PH_PAUSE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		SENSE_NONE = 2'd0,
		SENSE_FWD  = 2'd1,
		SENSE_REV  = 2'd2
	} sense_t;

	typedef enum logic [2:0] {
		DIR_STOP       = 3'd0,
		DIR_FWD        = 3'd1,
		DIR_LEFT       = 3'd2,
		DIR_RIGHT      = 3'd3,
		DIR_BACK       = 3'd4,
		DIR_ROLL_LEFT  = 3'd5,
		DIR_ROLL_RIGHT = 3'd6,
		DIR_NEUTRAL    = 3'd7
	} dir_t;

	typedef enum logic [2:0] {
		REG_LEFT_FWD_ROW   = 3'd0,
		REG_LEFT_REV_ROW   = 3'd1,
		REG_RIGHT_FWD_ROW  = 3'd2,
		REG_RIGHT_REV_ROW  = 3'd3,
		REG_FULL_FWD_OFFS  = 3'd4,
		REG_FULL_REV_OFFS  = 3'd5
	} reg_index_t;

	localparam logic [7:0] OFFSET_ROM [OFFSET_ROM_DEPTH] = '{
		8'd164, 8'd83, 8'd70, 8'd63, 8'd58, 8'd54, 8'd51, 8'd48, 8'd45, 8'd43,
		8'd41, 8'd40, 8'd38, 8'd37, 8'd35, 8'd34, 8'd33, 8'd32, 8'd31, 8'd30,
		8'd29, 8'd28, 8'd27, 8'd26, 8'd26, 8'd25, 8'd24, 8'd24, 8'd23, 8'd22,
		8'd22, 8'd21, 8'd21, 8'd20, 8'd19, 8'd19, 8'd18, 8'd18, 8'd17, 8'd17,
		8'd16, 8'd16, 8'd16, 8'd15, 8'd15, 8'd14, 8'd14, 8'd14, 8'd13, 8'd13,
		8'd12
	};

	function automatic logic [7:0] offset_rom_read(input logic [ROM_INDEX_WIDTH-1:0] idx);
		logic [7:0] val;
		if (int'(idx) > ROM_LAST) begin
			val = OFFSET_ROM[ROM_LAST];
		end else begin
			val = OFFSET_ROM[idx];
		end
		return val;
	endfunction

	function automatic sense_t left_sense(input dir_t dir);
		sense_t s;
		case (dir)
			DIR_FWD, DIR_RIGHT, DIR_ROLL_RIGHT: s = SENSE_FWD;
			DIR_BACK, DIR_ROLL_LEFT:            s = SENSE_REV;
			default:                            s = SENSE_NONE;
		endcase
		return s;
	endfunction

	function automatic sense_t right_sense(input dir_t dir);
		sense_t s;
		case (dir)
			DIR_FWD, DIR_LEFT, DIR_ROLL_LEFT: s = SENSE_FWD;
			DIR_BACK, DIR_ROLL_RIGHT:         s = SENSE_REV;
			default:                          s = SENSE_NONE;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/servo_drive_calibrated_reversal.sv =====
`timescale 1ns / 1ps

// Two-wheel servo drive with calibrated pulse widths and a pause on reversal.
// Input channel (in_valid / in_stall) carries one transaction per command:
// a drive request, a one millisecond tick or an immediate stop. Every input
// transaction gives exactly one output transaction (out_valid / out_stall)
// with the pulse widths now driven on both wheels and the drive phase.
// An accepted transaction sits in the input register, where the table
// selection, trim and clamp logic runs and the drive state is updated;
// its result is then loaded into the output register, raising out_valid.
// One transaction is taken every cycle while the output side keeps up.
// When the receiver stalls, the output register holds its result and the
// input register keeps the next transaction; in_stall rises only once both
// are full. The user writes calibration rows and full-speed offsets through
// the cfg port only while no transaction is in flight; nothing checks this.
// Reset clears valids, cfg and drive state: phase idle, last pulses zero.

module servo_drive_calibrated_reversal (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  direction,
	input  logic [3:0]  speed_level,
	input  logic signed [7:0] trim,
	input  logic [14:0] duration_ticks,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] left_pulse,
	output logic [11:0] right_pulse,
	output logic [1:0]  drive_phase
);

	localparam int PW = sdcr_pkg::PULSE_WIDTH;
	localparam int SW = sdcr_pkg::SUM_WIDTH;
	localparam int RW = sdcr_pkg::ROW_WIDTH;
	localparam int OW = sdcr_pkg::OFFSET_WIDTH;
	localparam int DW = sdcr_pkg::DURATION_WIDTH;
	localparam int CW = sdcr_pkg::COUNT_WIDTH;
	localparam int IW = sdcr_pkg::ROM_INDEX_WIDTH;

	// configuration
	logic [RW-1:0] lf_row_q, lr_row_q, rf_row_q, rr_row_q;
	logic [OW-1:0] ff_offs_q, fr_offs_q;

	// input register
	logic          valid_s1;
	logic [1:0]    command_s1;
	logic [2:0]    direction_s1;
	logic [3:0]    speed_s1;
	logic signed [7:0] trim_s1;
	logic [DW-1:0] duration_s1;

	// drive state
	sdcr_pkg::phase_t phase_q, phase_d;
	logic [CW-1:0] countdown_q, countdown_d;
	logic [PW-1:0] last_l_q, last_r_q, last_l_d, last_r_d;
	logic [PW-1:0] pend_l_q, pend_r_q, pend_l_d, pend_r_d;
	logic [DW-1:0] pend_dur_q, pend_dur_d;

	// output register
	logic          out_valid_q;
	logic [PW-1:0] left_q, right_q;
	logic [1:0]    phase_out_q;

	logic          go_s1;
	logic [2:0]    spd;
	logic signed [8:0] t_rnd;
	logic signed [9:0] t_bias;
	logic signed [6:0] t4;
	logic signed [OW:0] d_f, d_r;
	logic [IW-1:0] mag_f, mag_r;
	logic [7:0]    rom_f, rom_r;
	logic [PW-1:0] new_l, new_r;
	logic [PW:0]   mid_sum_l, mid_sum_r;
	logic [PW-1:0] mid_l, mid_r;
	logic          flip_l, flip_r;
	logic [CW-1:0] cnt_dec;

	function automatic logic [PW-1:0] row_level(input logic [RW-1:0] row, input logic [1:0] k);
		logic [PW-1:0] v;
		case (k)
			2'd0:    v = row[0*PW +: PW];
			2'd1:    v = row[1*PW +: PW];
			2'd2:    v = row[2*PW +: PW];
			default: v = row[3*PW +: PW];
		endcase
		return v;
	endfunction

	// magnitude of the clamped rom index
	function automatic logic [IW-1:0] rom_mag(input logic signed [OW:0] d);
		logic signed [OW:0] a;
		logic [IW-1:0] m;
		a = d[OW] ? -d : d;
		if (int'(d) >= sdcr_pkg::ROM_LAST || int'(d) <= -sdcr_pkg::ROM_LAST) begin
			m = IW'(sdcr_pkg::ROM_LAST);
		end else begin
			m = a[IW-1:0];
		end
		return m;
	endfunction

	function automatic logic flips(input logic [PW-1:0] old_p, input logic [PW-1:0] new_p,
			input logic [PW-1:0] mid);
		return (old_p != '0) && (new_p != '0) && ((old_p >= mid) != (new_p >= mid));
	endfunction

	function automatic logic [PW-1:0] wheel_pulse(
		input logic              is_right,
		input sdcr_pkg::sense_t  sense,
		input logic [2:0]        speed,
		input logic signed [7:0] trim_v,
		input logic signed [6:0] adj_v,
		input logic [RW-1:0]     frow,
		input logic [RW-1:0]     rrow,
		input logic              f_neg,
		input logic [7:0]        f_rom,
		input logic              r_neg,
		input logic [7:0]        r_rom
	);
		logic signed [SW-1:0] f0, r0, fk, rk, adj, fr, rr, sum;
		logic [PW-1:0] res;
		f0 = {2'b00, row_level(frow, 2'd0)};
		r0 = {2'b00, row_level(rrow, 2'd0)};
		fk = {2'b00, row_level(frow, speed[1:0])};
		rk = {2'b00, row_level(rrow, speed[1:0])};
		adj = {{(SW-7){adj_v[6]}}, adj_v};
		fr = {{(SW-8){1'b0}}, f_rom};
		rr = {{(SW-8){1'b0}}, r_rom};
		sum = '0;
		if (sense == sdcr_pkg::SENSE_NONE || speed == 3'd0) begin
			// creep from level zero when trimmed
			if (trim_v == 8'sd0) begin
				sum = '0;
			end else if (!trim_v[7]) begin
				sum = (is_right ? r0 : f0) + adj;
			end else begin
				sum = (is_right ? f0 : r0) + adj;
			end
		end else if (int'(speed) == sdcr_pkg::SPEED_FULL) begin
			if (sense == sdcr_pkg::SENSE_FWD) begin
				if (!is_right) begin
					sum = f_neg ? SW'(sdcr_pkg::MAX_WIDTH) : f0 + fr;
				end else begin
					sum = f_neg ? f0 - fr : SW'(sdcr_pkg::MIN_WIDTH);
				end
			end else begin
				if (!is_right) begin
					sum = r_neg ? SW'(sdcr_pkg::MIN_WIDTH) : r0 - rr;
				end else begin
					sum = r_neg ? r0 + rr : SW'(sdcr_pkg::MAX_WIDTH);
				end
			end
		end else if (sense == sdcr_pkg::SENSE_FWD) begin
			sum = fk + adj;
		end else begin
			sum = rk + adj;
		end
		if (sum[SW-1]) begin
			res = '0;
		end else if (sum[SW-2:PW] != '0) begin
			res = '1;
		end else begin
			res = sum[PW-1:0];
		end
		return res;
	endfunction

	// handshake
	assign go_s1 = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	// datapath
	assign spd = (speed_s1 > 4'(sdcr_pkg::SPEED_FULL)) ? 3'(sdcr_pkg::SPEED_FULL) : speed_s1[2:0];

	// trim / 4, rounded half away from zero
	assign t_rnd = {trim_s1[7], trim_s1} + (trim_s1[7] ? -9'sd2 : 9'sd2);
	assign t_bias = {t_rnd[8], t_rnd} + (t_rnd[8] ? 10'sd3 : 10'sd0);
	assign t4 = t_bias[8:2];

	assign d_f = {ff_offs_q[OW-1], ff_offs_q} - {{2{trim_s1[7]}}, trim_s1, 1'b0};
	assign d_r = {fr_offs_q[OW-1], fr_offs_q} - {{2{trim_s1[7]}}, trim_s1, 1'b0};
	assign mag_f = rom_mag(d_f);
	assign mag_r = rom_mag(d_r);
	assign rom_f = sdcr_pkg::offset_rom_read(mag_f);
	assign rom_r = sdcr_pkg::offset_rom_read(mag_r);

	assign new_l = wheel_pulse(1'b0, sdcr_pkg::left_sense(sdcr_pkg::dir_t'(direction_s1)),
		spd, trim_s1, t4, lf_row_q, lr_row_q, d_f[OW], rom_f, d_r[OW], rom_r);
	assign new_r = wheel_pulse(1'b1, sdcr_pkg::right_sense(sdcr_pkg::dir_t'(direction_s1)),
		spd, trim_s1, t4, rf_row_q, rr_row_q, d_f[OW], rom_f, d_r[OW], rom_r);

	assign mid_sum_l = {1'b0, lf_row_q[PW-1:0]} + {1'b0, lr_row_q[PW-1:0]};
	assign mid_sum_r = {1'b0, rf_row_q[PW-1:0]} + {1'b0, rr_row_q[PW-1:0]};
	assign mid_l = mid_sum_l[PW:1];
	assign mid_r = mid_sum_r[PW:1];
	assign flip_l = flips(last_l_q, new_l, mid_l);
	assign flip_r = flips(last_r_q, new_r, mid_r);

	assign cnt_dec = (countdown_q != '0) ? countdown_q - CW'(1) : '0;

	always_comb begin
		phase_d = phase_q;
		countdown_d = countdown_q;
		last_l_d = last_l_q;
		last_r_d = last_r_q;
		pend_l_d = pend_l_q;
		pend_r_d = pend_r_q;
		pend_dur_d = pend_dur_q;
		case (sdcr_pkg::cmd_t'(command_s1))
			sdcr_pkg::CMD_DRIVE: begin
				if (direction_s1 == sdcr_pkg::DIR_NEUTRAL) begin
					last_l_d = PW'(sdcr_pkg::NEUTRAL_WIDTH);
					last_r_d = PW'(sdcr_pkg::NEUTRAL_WIDTH);
				end else begin
					last_l_d = flip_l ? '0 : new_l;
					last_r_d = flip_r ? '0 : new_r;
					if (flip_l || flip_r) begin
						phase_d = sdcr_pkg::PH_PAUSE;
						countdown_d = CW'(sdcr_pkg::REVERSE_PAUSE_TICKS);
						pend_l_d = new_l;
						pend_r_d = new_r;
						pend_dur_d = duration_s1;
					end else if (duration_s1 != '0) begin
						phase_d = sdcr_pkg::PH_TIMED;
						countdown_d = {1'b0, duration_s1};
					end else begin
						phase_d = sdcr_pkg::PH_IDLE;
						countdown_d = '0;
					end
				end
			end
			sdcr_pkg::CMD_TICK: begin
				if (phase_q != sdcr_pkg::PH_IDLE) begin
					countdown_d = cnt_dec;
					if (cnt_dec == '0) begin
						if (phase_q == sdcr_pkg::PH_PAUSE) begin
							// pause over: apply the held request
							last_l_d = pend_l_q;
							last_r_d = pend_r_q;
							if (pend_dur_q != '0) begin
								phase_d = sdcr_pkg::PH_TIMED;
								countdown_d = {1'b0, pend_dur_q};
							end else begin
								phase_d = sdcr_pkg::PH_IDLE;
							end
						end else begin
							phase_d = sdcr_pkg::PH_IDLE;
							last_l_d = '0;
							last_r_d = '0;
						end
					end
				end
			end
			sdcr_pkg::CMD_HALT: begin
				phase_d = sdcr_pkg::PH_IDLE;
				countdown_d = '0;
				last_l_d = '0;
				last_r_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lf_row_q <= '0;
			lr_row_q <= '0;
			rf_row_q <= '0;
			rr_row_q <= '0;
			ff_offs_q <= '0;
			fr_offs_q <= '0;
		end else if (cfg_we) begin
			case (sdcr_pkg::reg_index_t'(cfg_index))
				sdcr_pkg::REG_LEFT_FWD_ROW:  lf_row_q <= cfg_data[RW-1:0];
				sdcr_pkg::REG_LEFT_REV_ROW:  lr_row_q <= cfg_data[RW-1:0];
				sdcr_pkg::REG_RIGHT_FWD_ROW: rf_row_q <= cfg_data[RW-1:0];
				sdcr_pkg::REG_RIGHT_REV_ROW: rr_row_q <= cfg_data[RW-1:0];
				sdcr_pkg::REG_FULL_FWD_OFFS: ff_offs_q <= cfg_data[OW-1:0];
				sdcr_pkg::REG_FULL_REV_OFFS: fr_offs_q <= cfg_data[OW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1 <= command;
			direction_s1 <= direction;
			speed_s1 <= speed_level;
			trim_s1 <= trim;
			duration_s1 <= duration_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdcr_pkg::PH_IDLE;
			countdown_q <= '0;
			last_l_q <= '0;
			last_r_q <= '0;
			pend_l_q <= '0;
			pend_r_q <= '0;
			pend_dur_q <= '0;
		end else if (go_s1) begin
			phase_q <= phase_d;
			countdown_q <= countdown_d;
			last_l_q <= last_l_d;
			last_r_q <= last_r_d;
			pend_l_q <= pend_l_d;
			pend_r_q <= pend_r_d;
			pend_dur_q <= pend_dur_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			left_q <= last_l_d;
			right_q <= last_r_d;
			phase_out_q <= phase_d;
		end
	end

	assign out_valid = out_valid_q;
	assign left_pulse = left_q;
	assign right_pulse = right_q;
	assign drive_phase = phase_out_q;

	// a running phase always has ticks left, idle never does
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sdcr_pkg::PH_IDLE) == (countdown_q == '0))
		else $error("phase and countdown disagree");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sdcr_pkg::PH_PAUSE |-> countdown_q <= CW'(sdcr_pkg::REVERSE_PAUSE_TICKS))
		else $error("reversal pause longer than configured");

	// a held transaction is not dropped while the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |=> valid_s1 && out_valid_q)
		else $error("transaction lost under output stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 |=> out_valid_q)
		else $error("result register not loaded");

endmodule
